// File: src/serial_adc_device_interface_assert.svh
// ----------------------------------------------------------------------------
// serial adc device interface assertion macros
// concurrent assertion wrappers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef SERIAL_ADC_DEVICE_INTERFACE_ASSERT_SVH
`define SERIAL_ADC_DEVICE_INTERFACE_ASSERT_SVH

`ifndef SYNTHESIS
// checked while out of reset
`define SADI_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define SADI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SADI_ASSERT(lbl, clk, rst_n, prop, msg)
`define SADI_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: src/sadi_pkg.sv
// ----------------------------------------------------------------------------
// sadi_pkg
// shared constants and item types of the serial adc device interface
// ----------------------------------------------------------------------------
package sadi_pkg;

    localparam int CODE_BITS = 8;
    localparam int FALL_W    = 4;
    localparam int RISE_W    = 2;
    localparam int PHASE_W   = 2;

    localparam logic [FALL_W-1:0] FALL_MAX  = 4'd15;
    localparam logic [RISE_W-1:0] RISE_MAX  = 2'd3;
    localparam logic [RISE_W-1:0] RISE_START = 2'd1;
    localparam logic [RISE_W-1:0] RISE_SGL   = 2'd2;

    localparam logic [PHASE_W-1:0] PH_IDLE   = 2'd0;
    localparam logic [PHASE_W-1:0] PH_INPUT  = 2'd1;
    localparam logic [PHASE_W-1:0] PH_OUTPUT = 2'd2;

    localparam logic [1:0] OP_CS   = 2'd0;
    localparam logic [1:0] OP_CLK  = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    typedef struct packed {
        logic [1:0]           operation;
        logic                 level;
        logic                 di_level;
        logic [CODE_BITS-1:0] ch0_code;
        logic [CODE_BITS-1:0] ch1_code;
    } t_in_item;

    typedef struct packed {
        logic               do_level;
        logic [PHASE_W-1:0] link_phase;
        logic               selected_channel;
    } t_out_item;

endpackage

// File: src/sadi_link_fsm.sv
// ----------------------------------------------------------------------------
// sadi_link_fsm
// frame state of the device link, next state and do view for one pin event
// ----------------------------------------------------------------------------
module sadi_link_fsm
    import sadi_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_fire,
    input  t_in_item  i_item,
    input  logic      i_three_wire,
    output t_out_item o_result
);

    logic [PHASE_W-1:0]   r_phase, n_phase;
    logic [RISE_W-1:0]    r_rise,  n_rise;
    logic [FALL_W-1:0]    r_fall,  n_fall;
    logic [1:0]           r_mux,   n_mux;
    logic [CODE_BITS-1:0] r_shift, n_shift;
    logic                 r_out,   n_out;

    logic [RISE_W-1:0] w_rise_inc;
    logic [FALL_W-1:0] w_fall_inc;
    logic [FALL_W-1:0] w_bit_pos;
    logic              w_odd;

    assign w_rise_inc = (r_rise < RISE_MAX) ? r_rise + 1'b1 : r_rise;
    assign w_fall_inc = (r_fall < FALL_MAX) ? r_fall + 1'b1 : r_fall;
    assign w_bit_pos  = FALL_W'(CODE_BITS) - w_fall_inc;
    assign w_odd      = r_mux[0] | i_item.di_level;

    always_comb begin
        n_phase = r_phase;
        n_rise  = r_rise;
        n_fall  = r_fall;
        n_mux   = r_mux;
        n_shift = r_shift;
        n_out   = r_out;
        unique case (i_item.operation)
            OP_CS: begin
                if (!i_item.level) begin
                    n_phase = PH_INPUT;
                    n_rise  = '0;
                    n_fall  = '0;
                    n_mux   = '0;
                    n_shift = '0;
                end else begin
                    n_phase = PH_IDLE;
                end
                n_out = 1'b1;
            end
            OP_CLK: begin
                if (i_item.level) begin
                    if (r_phase == PH_INPUT) begin
                        n_rise = w_rise_inc;
                        if (w_rise_inc == RISE_START) begin
                            if (!i_item.di_level) begin
                                n_phase = PH_IDLE;
                            end
                        end else if (w_rise_inc == RISE_SGL) begin
                            n_mux = {i_item.di_level, 1'b0};
                        end else begin
                            n_mux   = {r_mux[1], w_odd};
                            n_shift = w_odd ? i_item.ch1_code : i_item.ch0_code;
                            n_phase = PH_OUTPUT;
                            n_fall  = '0;
                            n_out   = 1'b0;
                        end
                    end
                end else if (r_phase == PH_OUTPUT) begin
                    n_fall = w_fall_inc;
                    if (w_fall_inc <= FALL_W'(CODE_BITS)) begin
                        n_out = r_shift[w_bit_pos[2:0]];
                    end else begin
                        n_out = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        if (n_phase == PH_OUTPUT) begin
            o_result.do_level = n_out;
        end else if (n_phase == PH_INPUT && i_three_wire) begin
            o_result.do_level = i_item.di_level;
        end else begin
            o_result.do_level = 1'b1;
        end
        o_result.link_phase       = n_phase;
        o_result.selected_channel = n_mux[0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_rise  <= '0;
            r_fall  <= '0;
            r_mux   <= '0;
            r_shift <= '0;
            r_out   <= 1'b1;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_rise  <= n_rise;
            r_fall  <= n_fall;
            r_mux   <= n_mux;
            r_shift <= n_shift;
            r_out   <= n_out;
        end
    end

endmodule

// File: src/serial_adc_device_interface.sv
// ----------------------------------------------------------------------------
// serial_adc_device_interface
// device side of a two-channel 8-bit serial adc link, one pin event per item
//
// channel   dir  handshake                       payload
// s_axis    in   s_axis_tvalid / s_axis_tready   pin event
// m_axis    out  m_axis_tvalid / m_axis_tready   do level and link status
// cfg       in   i_cfg_valid / o_cfg_ready       three wire mode
//
// one item per cycle while the output is not stalled; each item passes
// through the input register and then the result register before its result
// can be taken on m_axis, and a stall can hold it between the two
// synchronous active-low reset idles the link with do released high
// a stalled output holds the result, the input register still fills behind it
// ----------------------------------------------------------------------------
module serial_adc_device_interface
    import sadi_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // level, di_level, ch0_code[7:0], ch1_code[7:0]
    input  logic [1:0]  s_axis_tuser,  // operation[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // do_level, link_phase[1:0], selected_channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data
);

    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;
    logic      r_three_wire;
    logic      w_advance;
    logic      w_fire;
    t_out_item w_result;

    assign w_advance     = !r_out_valid || m_axis_tready;
    assign w_fire        = r_in_valid && w_advance;
    assign s_axis_tready = !r_in_valid || w_advance;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_three_wire <= 1'b0;
        end else if (i_cfg_valid) begin
            r_three_wire <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in.operation <= s_axis_tuser;
            r_in.level     <= s_axis_tdata[0];
            r_in.di_level  <= s_axis_tdata[1];
            r_in.ch0_code  <= s_axis_tdata[9:2];
            r_in.ch1_code  <= s_axis_tdata[17:10];
        end
    end

    sadi_link_fsm u_link_fsm (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (w_fire),
        .i_item       (r_in),
        .i_three_wire (r_three_wire),
        .o_result     (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out.selected_channel, r_out.link_phase, r_out.do_level};

`include "serial_adc_device_interface_assert.svh"

    `SADI_ASSERT(a_stall_full, i_clk, i_rst_n,
        !s_axis_tready |-> (r_in_valid && r_out_valid && !m_axis_tready),
        "input stalled with a free stage")
    `SADI_ASSERT(a_no_phantom, i_clk, i_rst_n,
        (!r_in_valid && m_axis_tready) |=> !r_out_valid,
        "result shown without a transaction")
    `SADI_ASSERT(a_idle_released, i_clk, i_rst_n,
        (r_out_valid && r_out.link_phase == PH_IDLE) |-> r_out.do_level,
        "do driven low while idle")
    `SADI_ASSERT_ALWAYS(a_reset_empty, i_clk,
        !i_rst_n |=> (!r_out_valid && !r_in_valid),
        "pipeline not empty after reset")

endmodule

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// drives pin events into the serial adc device interface and compares every
// do level, link phase and selected channel against a cycle-free model of
// the frame protocol, under random stalls on both streams and both modes
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import sadi_pkg::*;

    localparam logic [1:0] OP_SPARE   = 2'd3;
    localparam int         LONG_HOLD  = 300;
    localparam int         CYCLE_LIMIT = 400000;
    localparam int         PHASE_ITEMS = 280;

    class adc_link_model;
        logic [PHASE_W-1:0]   phase;
        logic [RISE_W-1:0]    rise_cnt;
        logic [FALL_W-1:0]    fall_cnt;
        logic [1:0]           mux_bits;
        logic [CODE_BITS-1:0] held_code;
        logic                 out_bit;
        logic                 three_wire;
        t_out_item            expected_status[$];
        int                   mismatches;

        function new();
            phase      = PH_IDLE;
            rise_cnt   = '0;
            fall_cnt   = '0;
            mux_bits   = '0;
            held_code  = '0;
            out_bit    = 1'b1;
            three_wire = 1'b0;
            mismatches = 0;
        endfunction

        function void note_event(logic [1:0] op, logic [23:0] payload);
            logic                 lvl;
            logic                 di;
            logic [CODE_BITS-1:0] c0;
            logic [CODE_BITS-1:0] c1;
            t_out_item            status;
            lvl = payload[0];
            di  = payload[1];
            c0  = payload[9:2];
            c1  = payload[17:10];
            if (op == OP_CS) begin
                if (!lvl) begin
                    phase     = PH_INPUT;
                    rise_cnt  = '0;
                    fall_cnt  = '0;
                    mux_bits  = '0;
                    held_code = '0;
                end else begin
                    phase = PH_IDLE;
                end
                out_bit = 1'b1;
            end else if (op == OP_CLK && phase != PH_IDLE) begin
                if (lvl) begin
                    if (phase == PH_INPUT) begin
                        if (rise_cnt != RISE_MAX)
                            rise_cnt = rise_cnt + 1'b1;
                        if (rise_cnt == RISE_START) begin
                            if (!di)
                                phase = PH_IDLE;
                        end else if (rise_cnt == RISE_SGL) begin
                            mux_bits = {di, 1'b0};
                        end else begin
                            mux_bits  = mux_bits | {1'b0, di};
                            held_code = mux_bits[0] ? c1 : c0;
                            phase     = PH_OUTPUT;
                            fall_cnt  = '0;
                            out_bit   = 1'b0;
                        end
                    end
                end else if (phase == PH_OUTPUT) begin
                    if (fall_cnt != FALL_MAX)
                        fall_cnt = fall_cnt + 1'b1;
                    if (fall_cnt <= CODE_BITS)
                        out_bit = held_code[CODE_BITS - fall_cnt];
                    else
                        out_bit = 1'b1;
                end
            end
            if (phase == PH_OUTPUT)
                status.do_level = out_bit;
            else if (phase == PH_INPUT && three_wire)
                status.do_level = di;
            else
                status.do_level = 1'b1;
            status.link_phase       = phase;
            status.selected_channel = mux_bits[0];
            expected_status.push_back(status);
        endfunction

        function void check_response(logic [7:0] rd);
            t_out_item want;
            if (expected_status.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual %h", $time, rd);
                return;
            end
            want = expected_status.pop_front();
            if (rd[0] !== want.do_level) begin
                mismatches++;
                $display("%0t: do_level expected %b actual %b", $time, want.do_level, rd[0]);
            end
            if (rd[2:1] !== want.link_phase) begin
                mismatches++;
                $display("%0t: link_phase expected %0d actual %0d",
                         $time, want.link_phase, rd[2:1]);
            end
            if (rd[3] !== want.selected_channel) begin
                mismatches++;
                $display("%0t: selected_channel expected %b actual %b",
                         $time, want.selected_channel, rd[3]);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_data = 1'b0;

    adc_link_model link_model = new();
    int            sent_count = 0;
    int            cycle_count = 0;
    int            stall_left = 0;
    logic          long_hold = 1'b0;
    logic          long_hold_seen = 1'b0;
    logic          tx_idle_on = 1'b1;
    logic          rx_idle_on = 1'b1;

    serial_adc_device_interface uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // result side back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
        end else if (long_hold && !long_hold_seen) begin
            m_axis_tready  <= 1'b0;
            stall_left     <= LONG_HOLD;
            long_hold_seen <= 1'b1;
        end else if (stall_left != 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= $urandom_range(0, 13);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                link_model.note_event(s_axis_tuser, s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                link_model.check_response(m_axis_tdata);
        end
    end

    function automatic logic coin();
        return logic'($urandom_range(0, 1));
    endfunction

    function automatic logic [7:0] pick_code();
        case ($urandom_range(0, 5))
            0: return 8'h00;
            1: return 8'hff;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic drive_pin(input logic [1:0] op, input logic lvl, input logic di,
                             input logic [7:0] c0, input logic [7:0] c1);
        if (tx_idle_on && $urandom_range(0, 7) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {6'd0, c1, c0, di, lvl};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sent_count++;
    endtask

    task automatic pin(input logic [1:0] op, input logic lvl, input logic di);
        drive_pin(op, lvl, di, pick_code(), pick_code());
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (link_model.expected_status.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic mode);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= mode;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        link_model.three_wire = mode;
        i_cfg_valid <= 1'b0;
    endtask

    // mostly well-formed frames with random content, some broken ones
    task automatic run_frame();
        int n_falls;
        pin(OP_CS, 1'b0, coin());
        repeat ($urandom_range(0, 2)) pin(OP_READ, coin(), coin());
        if ($urandom_range(0, 9) == 0)
            pin(OP_CLK, 1'b0, coin());
        pin(OP_CLK, 1'b1, $urandom_range(0, 9) != 0);
        if ($urandom_range(0, 3) == 0)
            pin(OP_READ, coin(), coin());
        pin(OP_CLK, 1'b1, coin());
        pin(OP_CLK, 1'b1, coin());
        n_falls = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 18) : $urandom_range(7, 10);
        repeat (n_falls) begin
            pin(OP_CLK, 1'b0, coin());
            if ($urandom_range(0, 2) == 0)
                pin(OP_READ, coin(), coin());
            if ($urandom_range(0, 15) == 0)
                pin(OP_CLK, 1'b1, coin());
            if ($urandom_range(0, 19) == 0)
                pin(OP_SPARE, coin(), coin());
        end
        if ($urandom_range(0, 6) != 0)
            pin(OP_CS, 1'b1, coin());
    endtask

    initial begin
        int target;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: idle corners, bad start bit, full frame with fall overflow
        tx_idle_on <= 1'b0;
        pin(OP_SPARE, 1'b1, 1'b1);
        pin(OP_CLK, 1'b1, 1'b1);
        pin(OP_CS, 1'b0, 1'b0);
        pin(OP_CLK, 1'b0, 1'b1);
        pin(OP_CLK, 1'b1, 1'b0);
        pin(OP_READ, 1'b0, 1'b0);
        pin(OP_CS, 1'b0, 1'b1);
        pin(OP_CLK, 1'b1, 1'b1);
        pin(OP_CLK, 1'b1, 1'b0);
        drive_pin(OP_CLK, 1'b1, 1'b1, 8'h00, 8'hff);
        pin(OP_CLK, 1'b1, 1'b1);
        repeat (16) pin(OP_CLK, 1'b0, coin());
        pin(OP_CS, 1'b1, 1'b0);
        wait_drained();

        write_mode(1'b1);
        pin(OP_CS, 1'b0, 1'b1);
        pin(OP_READ, 1'b1, 1'b0);
        pin(OP_READ, 1'b0, 1'b1);
        pin(OP_CLK, 1'b1, 1'b1);
        pin(OP_CLK, 1'b1, 1'b0);
        drive_pin(OP_CLK, 1'b1, 1'b0, 8'hff, 8'h00);
        pin(OP_CLK, 1'b0, 1'b0);
        pin(OP_CS, 1'b1, 1'b1);

        for (int ph = 0; ph < 6; ph++) begin
            wait_drained();
            write_mode(ph[0]);
            tx_idle_on <= (ph != 2) && (ph != 5);
            rx_idle_on <= (ph != 3) && (ph != 5);
            if (ph == 1)
                long_hold <= 1'b1;
            target = sent_count + PHASE_ITEMS;
            while (sent_count < target) begin
                if ($urandom_range(0, 9) == 0)
                    pin(2'($urandom_range(0, 3)), coin(), coin());
                else
                    run_frame();
            end
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (link_model.mismatches == 0 && link_model.expected_status.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: sim.f
+incdir+src
src/sadi_pkg.sv
src/sadi_link_fsm.sv
src/serial_adc_device_interface.sv
dv/testbench.sv
